// ----- rtl/lpr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int AGE_W       = 16;
  localparam int FAULT_W     = 32;
  localparam int CFG_W       = 5;
  localparam int FRAME_IDX_W = 4;

  localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FIU_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } lpr_state_t;

endpackage

// ----- rtl/lru_page_replacement.sv -----
// LRU page replacement, top level: sequencer, valid bits, fault counter.
// Sequence: accept, scan one frame per cycle through the single read port of
// the frame store (n = active frame count), drain, update (waits while a result is held).
// No new input beat is accepted (in_stall) until the update of the last one is done.
// Reset: valid bits and fault count cleared, frames_in_use = 16, no sweep.
// Depends on lpr_pkg, lpr_frame_store, lpr_scan.
`timescale 1ns / 1ps

module lru_page_replacement import lpr_pkg::*; #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PAGE_WIDTH-1:0]  in_page_number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [FRAME_IDX_W-1:0] out_frame_index,
  output logic                   out_evicted_valid,
  output logic [PAGE_WIDTH-1:0]  out_evicted_page,
  output logic [FAULT_W-1:0]     out_fault_count
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  lpr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]       frames_in_use_r;
  logic [PAGE_WIDTH-1:0]  page_r;
  logic [IDX_W-1:0]       last_idx_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   d_vld_r;
  logic [IDX_W-1:0]       d_idx_r;
  logic [NUM_FRAMES-1:0]  frame_valid_r;
  logic [FAULT_W-1:0]     fault_cnt_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [FRAME_IDX_W-1:0] out_frame_index_r;
  logic                   out_evicted_valid_r;
  logic [PAGE_WIDTH-1:0]  out_evicted_page_r;

  logic [CMP_W-1:0]       fiu_ext;
  logic [CNT_W-1:0]       n_eff;
  logic                   in_acc;
  logic                   rd_en;
  logic                   upd_go;
  logic [PAGE_WIDTH-1:0]  rd_page;
  logic [AGE_W-1:0]       rd_age;
  logic [AGE_W-1:0]       age_inc;
  logic                   scan_hit;
  logic                   scan_empty;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       empty_idx;
  logic [IDX_W-1:0]       old_idx;
  logic [PAGE_WIDTH-1:0]  old_page;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W+FRAME_IDX_W-1:0] slot_ext;
  logic                   ev_valid;
  logic                   age_we;
  logic [IDX_W-1:0]       age_waddr;
  logic [AGE_W-1:0]       age_wdata;
  logic [FAULT_W-1:0]     fault_cnt_nxt;

  // active frame count: 0 acts as 1, clamp to NUM_FRAMES
  assign fiu_ext = CMP_W'(frames_in_use_r);
  always_comb begin
    if (fiu_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (fiu_ext > CMP_W'(NUM_FRAMES)) begin
      n_eff = CNT_W'(NUM_FRAMES);
    end else begin
      n_eff = CNT_W'(fiu_ext);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rd_en    = (state_r == S_SCAN);
  assign upd_go   = (state_r == S_UPDATE) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_r == last_idx_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FIU_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r     <= in_page_number;
      last_idx_r <= IDX_W'(n_eff - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      d_vld_r  <= 1'b0;
    end else begin
      d_vld_r <= rd_en;
      if (in_acc) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx_r <= rd_idx_r;
  end

  lpr_frame_store #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_idx_r),
    .rd_page    (rd_page),
    .rd_age     (rd_age),
    .page_we    (upd_go && !scan_hit),
    .page_waddr (slot),
    .page_wdata (page_r),
    .age_we     (age_we),
    .age_waddr  (age_waddr),
    .age_wdata  (age_wdata)
  );

  lpr_scan #(
    .PAGE_WIDTH (PAGE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (in_acc),
    .en        (d_vld_r),
    .idx       (d_idx_r),
    .target    (page_r),
    .frm_valid (frame_valid_r[d_idx_r]),
    .frm_page  (rd_page),
    .frm_age   (rd_age),
    .age_inc   (age_inc),
    .hit       (scan_hit),
    .hit_idx   (hit_idx),
    .empty     (scan_empty),
    .empty_idx (empty_idx),
    .old_idx   (old_idx),
    .old_page  (old_page)
  );

  always_comb begin
    if (scan_hit) begin
      slot = hit_idx;
    end else if (scan_empty) begin
      slot = empty_idx;
    end else begin
      slot = old_idx;
    end
  end

  assign ev_valid = !scan_hit && !scan_empty;
  assign slot_ext = {{FRAME_IDX_W{1'b0}}, slot};

  // aging write-back during the scan; chosen frame ends at age one
  assign age_we    = d_vld_r || upd_go;
  assign age_waddr = upd_go ? slot : d_idx_r;
  assign age_wdata = upd_go ? AGE_W'(1) : age_inc;

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (!scan_hit && (fault_cnt_r != FAULT_MAX)) begin
      fault_cnt_nxt = fault_cnt_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_cnt_r   <= '0;
    end else if (upd_go) begin
      frame_valid_r[slot] <= 1'b1;
      fault_cnt_r         <= fault_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r           <= scan_hit;
      out_frame_index_r   <= slot_ext[FRAME_IDX_W-1:0];
      out_evicted_valid_r <= ev_valid;
      out_evicted_page_r  <= ev_valid ? old_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_count   = fault_cnt_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= last_idx_r))
    else $error("scan index beyond active frames");

  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && ev_valid) |-> frame_valid_r[old_idx])
    else $error("eviction of an empty frame");

  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && !scan_hit) |=> (fault_cnt_r != '0))
    else $error("fault not counted");

  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> (out_valid_r && out_hit == $past(scan_hit) && frame_valid_r[$past(slot)]))
    else $error("result or frame valid missing after update");

endmodule

// ----- rtl/lpr_frame_store.sv -----
// Frame store: page number and age per frame, one write port each, one
// registered read port. Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_frame_store import lpr_pkg::*; #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [PAGE_WIDTH-1:0] rd_page,
  output logic [AGE_W-1:0]      rd_age,
  input  logic                  page_we,
  input  logic [IDX_W-1:0]      page_waddr,
  input  logic [PAGE_WIDTH-1:0] page_wdata,
  input  logic                  age_we,
  input  logic [IDX_W-1:0]      age_waddr,
  input  logic [AGE_W-1:0]      age_wdata
);

  logic [PAGE_WIDTH-1:0] page_mem [NUM_FRAMES];
  logic [AGE_W-1:0]      age_mem  [NUM_FRAMES];
  logic [PAGE_WIDTH-1:0] rd_page_r;
  logic [AGE_W-1:0]      rd_age_r;

  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
    if (rd_en) begin
      rd_page_r <= page_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (rd_en) begin
      rd_age_r <= age_mem[rd_addr];
    end
  end

  assign rd_page = rd_page_r;
  assign rd_age  = rd_age_r;

endmodule

// ----- rtl/lpr_scan.sv -----
// Scan unit: one frame per beat of the scan, page compare, empty
// search, oldest-age compare and saturating age increment. Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_scan import lpr_pkg::*; #(
  parameter int PAGE_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  en,
  input  logic [IDX_W-1:0]      idx,
  input  logic [PAGE_WIDTH-1:0] target,
  input  logic                  frm_valid,
  input  logic [PAGE_WIDTH-1:0] frm_page,
  input  logic [AGE_W-1:0]      frm_age,
  output logic [AGE_W-1:0]      age_inc,
  output logic                  hit,
  output logic [IDX_W-1:0]      hit_idx,
  output logic                  empty,
  output logic [IDX_W-1:0]      empty_idx,
  output logic [IDX_W-1:0]      old_idx,
  output logic [PAGE_WIDTH-1:0] old_page
);

  logic                  hit_r;
  logic                  empty_r;
  logic                  first_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [IDX_W-1:0]      empty_idx_r;
  logic [IDX_W-1:0]      old_idx_r;
  logic [AGE_W-1:0]      old_age_r;
  logic [PAGE_WIDTH-1:0] old_page_r;
  logic                  match;
  logic                  older;

  assign match   = frm_valid && (frm_page == target);
  assign older   = first_r || (frm_age > old_age_r);
  assign age_inc = (frm_age == AGE_MAX) ? frm_age : frm_age + AGE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
      first_r <= 1'b1;
    end else if (en) begin
      first_r <= 1'b0;
      if (!hit_r && match) begin
        hit_r <= 1'b1;
      end
      if (!empty_r && !frm_valid) begin
        empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!hit_r && match) begin
        hit_idx_r <= idx;
      end
      if (!empty_r && !frm_valid) begin
        empty_idx_r <= idx;
      end
      if (older) begin
        old_idx_r  <= idx;
        old_age_r  <= frm_age;
        old_page_r <= frm_page;
      end
    end
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign empty     = empty_r;
  assign empty_idx = empty_idx_r;
  assign old_idx   = old_idx_r;
  assign old_page  = old_page_r;

endmodule

// ----- dv/tb_lru_page_replacement.sv -----
// Self-checking testbench for lru_page_replacement: LRU age-counter predictor,
// queue-fed burst driver, stalling monitor, frame-count reprogramming phases.
// Depends on lpr_pkg and the lru_page_replacement RTL.
`timescale 1ns / 1ps

module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam int NFRAMES     = 16;
  localparam int PW          = 16;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PW-1:0]          evicted_page;
    logic [FAULT_W-1:0]     fault_count;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PW-1:0]          in_page_number = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_index;
  logic                   out_evicted_valid;
  logic [PW-1:0]          out_evicted_page;
  logic [FAULT_W-1:0]     out_fault_count;

  lru_page_replacement #(
    .NUM_FRAMES(NFRAMES),
    .PAGE_WIDTH(PW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count)
  );

  // predictor state
  logic [PW-1:0]      frame_page [NFRAMES];
  bit                 frame_valid [NFRAMES];
  logic [AGE_W-1:0]   frame_age [NFRAMES];
  logic [FAULT_W-1:0] fault_total;
  logic [CFG_W-1:0]   frames_cfg;

  logic [PW-1:0]  page_q [$];
  access_result_t access_q [$];
  access_result_t want;
  access_result_t got;

  bit page_taken = 1'b0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int active_frames(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > NFRAMES) return NFRAMES;
    return int'(v);
  endfunction

  function automatic void lru_clear();
    for (int i = 0; i < NFRAMES; i++) begin
      frame_page[i]  = '0;
      frame_valid[i] = 1'b0;
      frame_age[i]   = AGE_MAX;
    end
    fault_total = '0;
    frames_cfg  = FIU_RESET;
  endfunction

  function automatic access_result_t lru_access(logic [PW-1:0] page);
    access_result_t r;
    int n;
    int slot;
    int oldest;
    bit found;
    bit have_empty;
    r = '0;
    n = active_frames(frames_cfg);
    slot = 0;
    oldest = 0;
    found = 1'b0;
    have_empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_valid[i] && frame_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      frame_age[slot] = '0;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!have_empty) begin
          if (!frame_valid[i]) begin
            have_empty = 1'b1;
            slot = i;
          end else if (frame_age[i] > frame_age[oldest]) begin
            oldest = i;
          end
        end
      end
      if (!have_empty) begin
        slot = oldest;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[slot];
      end
      frame_page[slot]  = page;
      frame_valid[slot] = 1'b1;
      frame_age[slot]   = '0;
      if (fault_total != FAULT_MAX) fault_total = fault_total + FAULT_W'(1);
    end
    for (int i = 0; i < n; i++) begin
      if (frame_age[i] != AGE_MAX) frame_age[i] = frame_age[i] + AGE_W'(1);
    end
    r.hit         = found;
    r.frame_index = FRAME_IDX_W'(slot);
    r.fault_count = fault_total;
    return r;
  endfunction

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!in_valid || page_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (page_q.size() != 0) begin
        in_valid <= 1'b1;
        in_page_number <= page_q.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 10);
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with long hold-offs to back up the block
  int rx_cycle = 0;
  int hold_left = 0;
  int next_hold = 150;

  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (results_seen >= next_hold) begin
      hold_left = 300;
      next_hold = next_hold + 800;
      out_stall <= 1'b1;
    end else begin
      case ((rx_cycle >> 6) % 6)
        0, 1: out_stall <= 1'b0;
        2: out_stall <= ($urandom_range(0, 3) == 0);
        3: out_stall <= rx_cycle[0];
        4: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // monitor: check result beats, then track config writes and input beats
  always @(posedge clk) begin
    page_taken <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      lru_clear();
      access_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_frame_index, out_evicted_valid, out_evicted_page,
               out_fault_count};
        if (access_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("unexpected result beat %0d: hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                     results_seen, got.hit, got.frame_index, got.evicted_valid,
                     got.evicted_page, got.fault_count);
        end else begin
          want = access_q.pop_front();
          if (got !== want) begin
            error_count = error_count + 1;
            if (error_count <= 10) begin
              $display("mismatch on result %0d: exp hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                       results_seen, want.hit, want.frame_index, want.evicted_valid,
                       want.evicted_page, want.fault_count);
              $display("  got hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                       got.hit, got.frame_index, got.evicted_valid,
                       got.evicted_page, got.fault_count);
            end
          end
        end
        results_seen = results_seen + 1;
      end
      if (cfg_wr_en) frames_cfg = cfg_wr_data;
      if (in_valid && !in_stall) access_q.push_back(lru_access(in_page_number));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (page_q.size() != 0 || in_valid || access_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // working-set traffic so that hits, fills and evictions all occur
  task automatic add_pages(int count, int pool);
    logic [PW-1:0] base;
    base = PW'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) page_q.push_back(PW'($urandom));
      else page_q.push_back(base + PW'($urandom_range(0, pool - 1)));
    end
  endtask

  logic [CFG_W-1:0] phase_cfg [6] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8};
  logic [CFG_W-1:0] fiu;
  int n;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // page extremes, hits, fill all frames, then evict the oldest
    page_q.push_back('0);
    page_q.push_back('1);
    page_q.push_back('0);
    page_q.push_back('1);
    for (int p = 1; p <= 14; p++) page_q.push_back(PW'(p));
    page_q.push_back(16'h8000);
    page_q.push_back(16'h5555);
    page_q.push_back(16'hAAAA);
    wait_idle();

    // zero frames acts as one; frames above stay resident
    write_frames(5'd0);
    page_q.push_back(16'd7);
    page_q.push_back(16'd7);
    page_q.push_back(16'd9);
    wait_idle();

    // oversize count acts as full; untouched frames come back with contents
    write_frames(5'd31);
    page_q.push_back(16'd3);
    page_q.push_back(16'd9);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      fiu = (ph < 6) ? phase_cfg[ph] : CFG_W'($urandom_range(0, 31));
      write_frames(fiu);
      n = active_frames(fiu);
      add_pages(150, n + $urandom_range(1, n + 4));
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
